// File: rtl/kfr_pkg.sv
// Shared types, opcodes and the round function for the Keccak-f[1600] round block.
// No dependencies; used by kfr_ctrl, kfr_datapath, keccak_f1600_round and tb.
package kfr_pkg;

    typedef logic [63:0] t_lane;
    typedef t_lane       t_state [25];

    // Opcodes of a request; the unused code behaves as a read
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_ROUND = 2'd2;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;     // capture the request fields
        logic exec;     // apply write or round to the state
        logic capture;  // load the result register
    } t_cmd;

    // rho offsets, indexed [x][y]
    localparam logic [5:0] RHO_OFS [5][5] = '{
        '{6'd0,  6'd36, 6'd3,  6'd41, 6'd18},
        '{6'd1,  6'd44, 6'd10, 6'd45, 6'd2},
        '{6'd62, 6'd6,  6'd43, 6'd15, 6'd61},
        '{6'd28, 6'd55, 6'd25, 6'd21, 6'd56},
        '{6'd27, 6'd20, 6'd39, 6'd8,  6'd14}
    };

    // Rotate left; a zero amount leaves the lane as it is
    function automatic t_lane rotl(t_lane v, logic [5:0] n);
        logic [127:0] w;
        w = {v, v} << n;
        return w[127:64];
    endfunction

    // One full round: theta, rho, pi, chi, iota
    function automatic t_state keccak_round(t_state a_in, t_lane rc);
        t_lane  c [5];
        t_lane  d [5];
        t_state a;
        t_state b;
        t_state r;
        a = a_in;
        for (int x = 0; x < 5; x++) begin
            c[x] = a[x] ^ a[x + 5] ^ a[x + 10] ^ a[x + 15] ^ a[x + 20];
        end
        for (int x = 0; x < 5; x++) begin
            d[x] = c[(x + 4) % 5] ^ rotl(c[(x + 1) % 5], 6'd1);
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                a[x + 5 * y] = a[x + 5 * y] ^ d[x];
            end
        end
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                b[y + 5 * ((2 * x + 3 * y) % 5)] = rotl(a[x + 5 * y], RHO_OFS[x][y]);
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                r[x + 5 * y] = b[x + 5 * y] ^
                    (~b[(x + 1) % 5 + 5 * y] & b[(x + 2) % 5 + 5 * y]);
            end
        end
        r[0] = r[0] ^ rc;
        return r;
    endfunction

endpackage

// File: rtl/kfr_ctrl.sv
// Request sequencer for the Keccak-f[1600] round block.
// Depends on kfr_pkg for the command struct.
module kfr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output logic          o_valid,
    output kfr_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE    = 2'd0;
    localparam logic [1:0] S_EXEC    = 2'd1;
    localparam logic [1:0] S_CAPTURE = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_valid;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:    if (start) n_state = S_EXEC;
            S_EXEC:    n_state = S_CAPTURE;
            S_CAPTURE: n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_CAPTURE);
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_valid       = r_valid;
    assign o_cmd.load    = (r_state == S_IDLE) && start;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.capture = (r_state == S_CAPTURE);

endmodule

// File: rtl/kfr_datapath.sv
// State lanes, round logic and result register of the Keccak-f[1600] round block.
// Depends on kfr_pkg for lane types, opcodes and the round function.
module kfr_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kfr_pkg::t_cmd i_cmd,
    input  logic [1:0]    i_opcode,
    input  logic [2:0]    i_lane_x,
    input  logic [2:0]    i_lane_y,
    input  logic [63:0]   i_lane_value,
    input  logic [63:0]   i_round_constant,
    output logic [63:0]   o_lane_out
);

    kfr_pkg::t_state r_lanes;
    kfr_pkg::t_state n_round;
    logic [1:0]      r_op;
    logic [2:0]      r_lx;
    logic [2:0]      r_ly;
    logic [63:0]     r_val;
    logic [63:0]     r_rc;
    logic [63:0]     r_lane_out;
    logic            addr_ok;
    logic [4:0]      idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op <= i_opcode;
            r_lx <= i_lane_x;
            r_ly <= i_lane_y;
            r_val <= i_lane_value;
            r_rc <= i_round_constant;
        end
    end

    assign addr_ok = (r_lx < 3'd5) && (r_ly < 3'd5);
    // x + 5y, forced to zero for an address off the grid
    assign idx     = addr_ok ? (5'(r_lx) + {r_ly, 2'b00} + 5'(r_ly)) : 5'd0;
    assign n_round = kfr_pkg::keccak_round(r_lanes, r_rc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 25; i++) begin
                r_lanes[i] <= '0;
            end
        end else if (i_cmd.exec) begin
            case (r_op)
                kfr_pkg::OP_WRITE: if (addr_ok) r_lanes[idx] <= r_val;
                kfr_pkg::OP_ROUND: r_lanes <= n_round;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_lane_out <= addr_ok ? r_lanes[idx] : 64'd0;
        end
    end

    assign o_lane_out = r_lane_out;

endmodule

// File: rtl/keccak_f1600_round.sv
// Top level of the Keccak-f[1600] single-round engine.
// Depends on kfr_pkg, kfr_ctrl and kfr_datapath.
//
// The block holds the 5x5 Keccak state as 25 lanes of 64 bits, all zero after
// reset. A request is taken on a rising edge where start is high and busy is
// low. Opcode write stores lane_value in lane (lane_x, lane_y); read leaves the
// state alone (the unused opcode reads too); round applies theta, rho, pi, chi
// and iota to the whole state, XORing round_constant into lane (0,0). Every
// request returns one result: the addressed lane as it stands after the
// operation, or zero when either coordinate is above 4 (a write to such an
// address is dropped, a round still runs). A request passes through capture,
// execute and result load; busy is high during execute and result load, and
// o_valid is high for exactly one cycle as busy falls, in which a new request
// may already be accepted. The receiver cannot stall: take o_lane_out in the
// cycle that o_valid marks; it is held only until the next result load.
module keccak_f1600_round (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_opcode,
    input  logic [2:0]  i_lane_x,
    input  logic [2:0]  i_lane_y,
    input  logic [63:0] i_lane_value,
    input  logic [63:0] i_round_constant,
    output logic        o_valid,
    output logic [63:0] o_lane_out
);

    // Command bundle from sequencer to datapath
    kfr_pkg::t_cmd cmd;

    // Sequence each request through capture, execute and result load
    kfr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_valid (o_valid),
        .o_cmd   (cmd)
    );

    // Hold the state, apply the operation and register the result lane
    kfr_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_opcode         (i_opcode),
        .i_lane_x         (i_lane_x),
        .i_lane_y         (i_lane_y),
        .i_lane_value     (i_lane_value),
        .i_round_constant (i_round_constant),
        .o_lane_out       (o_lane_out)
    );

endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// Testbench for keccak_f1600_round: lane writes, lane reads and single rounds,
// each result checked against a behavioural lane model kept here. Depends on kfr_pkg.
module tb;

    localparam int          CLK_PERIOD      = 12;
    localparam int          RESET_CYCLES    = 9;
    localparam int          RANDOM_REQUESTS = 680;
    localparam int          TAIL_CYCLES     = 8;
    localparam int          MAX_REPORTED    = 10;
    localparam longint      TIMEOUT_NS      = 3_000_000;
    // Spare opcode: the block treats it as a read
    localparam logic [1:0]  OP_UNUSED       = 2'd3;

    // rho rotation per lane, lane (x, y) at index x + 5*y
    localparam int ROT_OFFSET [25] = '{
        0,  1,  62, 28, 27,
        36, 44, 6,  55, 20,
        3,  10, 43, 25, 39,
        41, 45, 15, 21, 8,
        18, 2,  61, 56, 14
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  i_opcode;
    logic [2:0]  i_lane_x;
    logic [2:0]  i_lane_y;
    logic [63:0] i_lane_value;
    logic [63:0] i_round_constant;
    logic        o_valid;
    logic [63:0] o_lane_out;

    // Model of the 25 lanes, zero after reset, and the lane values still owed
    kfr_pkg::t_lane lane_model [25] = '{default: '0};
    kfr_pkg::t_lane lane_expect_q [$];
    int             fault_count = 0;

    keccak_f1600_round u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_opcode         (i_opcode),
        .i_lane_x         (i_lane_x),
        .i_lane_y         (i_lane_y),
        .i_lane_value     (i_lane_value),
        .i_round_constant (i_round_constant),
        .o_valid          (o_valid),
        .o_lane_out       (o_lane_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hard stop in case the block stops answering
    initial begin
        #(TIMEOUT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Lane model
    // ------------------------------------------------------------------

    function automatic kfr_pkg::t_lane rotate_left(kfr_pkg::t_lane v, int unsigned n);
        if (n == 0) return v;
        return (v << n) | (v >> (64 - n));
    endfunction

    // Apply theta, rho, pi, chi and iota to the model state
    function automatic void run_round(kfr_pkg::t_lane rc);
        kfr_pkg::t_lane col   [5];
        kfr_pkg::t_lane dlt   [5];
        kfr_pkg::t_lane mixed [25];
        kfr_pkg::t_lane moved [25];
        for (int x = 0; x < 5; x++) begin
            col[x] = lane_model[x] ^ lane_model[x + 5] ^ lane_model[x + 10] ^
                     lane_model[x + 15] ^ lane_model[x + 20];
        end
        for (int x = 0; x < 5; x++) begin
            dlt[x] = col[(x + 4) % 5] ^ rotate_left(col[(x + 1) % 5], 1);
        end
        for (int i = 0; i < 25; i++) begin
            mixed[i] = lane_model[i] ^ dlt[i % 5];
        end
        // lane (x, y) moves to (y, 2x + 3y) after its rotation
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                moved[y + 5 * ((2 * x + 3 * y) % 5)] =
                    rotate_left(mixed[x + 5 * y], ROT_OFFSET[x + 5 * y]);
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                lane_model[x + 5 * y] = moved[x + 5 * y] ^
                    (~moved[(x + 1) % 5 + 5 * y] & moved[(x + 2) % 5 + 5 * y]);
            end
        end
        lane_model[0] = lane_model[0] ^ rc;
    endfunction

    // Update the model for one request and return the lane it must report
    function automatic kfr_pkg::t_lane predict_request(logic [1:0] op, logic [2:0] x,
                                                       logic [2:0] y, kfr_pkg::t_lane val,
                                                       kfr_pkg::t_lane rc);
        logic in_range;
        int   idx;
        in_range = (x < 3'd5) && (y < 3'd5);
        idx      = in_range ? int'(x) + 5 * int'(y) : 0;
        if (op == kfr_pkg::OP_WRITE) begin
            if (in_range) lane_model[idx] = val;
        end else if (op == kfr_pkg::OP_ROUND) begin
            run_round(rc);
        end
        return in_range ? lane_model[idx] : '0;
    endfunction

    function automatic void note_fault(string what);
        fault_count++;
        if (fault_count <= MAX_REPORTED) $display("%0t ns: %s", $realtime, what);
    endfunction

    // ------------------------------------------------------------------
    // Monitor: check the result first, then log any request taken at this
    // edge. Both live in one process so a result and an acceptance on the
    // same edge never race over the queue.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        kfr_pkg::t_lane want;
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) begin
                if (lane_expect_q.size() == 0) begin
                    note_fault($sformatf("result %h with no request outstanding",
                                         o_lane_out));
                end else begin
                    want = lane_expect_q.pop_front();
                    if (o_lane_out !== want) begin
                        note_fault($sformatf("lane_out mismatch: expected %h, got %h",
                                             want, o_lane_out));
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                lane_expect_q.push_back(predict_request(i_opcode, i_lane_x, i_lane_y,
                                                        i_lane_value, i_round_constant));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------

    // Present one request and hold it until the block takes it. Start stays
    // high on return; the caller either sends again or holds off.
    task automatic send_request(logic [1:0] op, logic [2:0] x, logic [2:0] y,
                                kfr_pkg::t_lane val, kfr_pkg::t_lane rc);
        start            <= 1'b1;
        i_opcode         <= op;
        i_lane_x         <= x;
        i_lane_y         <= y;
        i_lane_value     <= val;
        i_round_constant <= rc;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    // Drop start for a number of cycles
    task automatic hold_off(int cycles);
        if (cycles == 0) return;
        start <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Drop start and wait until every outstanding request has answered;
    // sample the queue on the falling edge, clear of the monitor.
    task automatic wait_for_results();
        start <= 1'b0;
        do @(negedge i_clk); while (lane_expect_q.size() != 0);
        @(posedge i_clk);
    endtask

    function automatic kfr_pkg::t_lane rand_lane();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return 64'd1 << $urandom_range(0, 63);
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // Mostly legal coordinates, now and then one above 4
    function automatic logic [2:0] rand_coord();
        if ($urandom_range(0, 9) == 0) return 3'($urandom_range(5, 7));
        return 3'($urandom_range(0, 4));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Corner lanes, corner values, the spare opcode, ignored fields
    task automatic test_lane_access();
        send_request(kfr_pkg::OP_READ,  3'd0, 3'd0, '1, '1);
        send_request(kfr_pkg::OP_WRITE, 3'd0, 3'd0, '1, '1);
        send_request(kfr_pkg::OP_WRITE, 3'd4, 3'd4, 64'h8000_0000_0000_0001, '0);
        send_request(kfr_pkg::OP_READ,  3'd4, 3'd4, '0, '1);
        send_request(kfr_pkg::OP_READ,  3'd0, 3'd0, 64'h1234_5678_9abc_def0, '0);
        send_request(kfr_pkg::OP_READ,  3'd2, 3'd3, '0, '0);
        send_request(OP_UNUSED,         3'd4, 3'd4, '1, '1);
        wait_for_results();
    endtask

    // Coordinates above 4: writes dropped, result zero, rounds still run
    task automatic test_bad_coordinates();
        send_request(kfr_pkg::OP_WRITE, 3'd5, 3'd0, 64'hdead_beef_cafe_f00d, '0);
        send_request(kfr_pkg::OP_READ,  3'd7, 3'd7, '0, '0);
        send_request(kfr_pkg::OP_WRITE, 3'd0, 3'd7, '1, '0);
        send_request(kfr_pkg::OP_ROUND, 3'd6, 3'd1, '0, 64'h0000_0000_0000_8082);
        send_request(OP_UNUSED,         3'd1, 3'd5, '0, '0);
        send_request(kfr_pkg::OP_READ,  3'd0, 3'd0, '0, '0);
        wait_for_results();
    endtask

    // Rounds with extreme constants, read back through several lanes
    task automatic test_round_cases();
        send_request(kfr_pkg::OP_ROUND, 3'd0, 3'd0, '1, '1);
        send_request(kfr_pkg::OP_ROUND, 3'd4, 3'd4, '0, '0);
        send_request(kfr_pkg::OP_ROUND, 3'd1, 3'd0, '0, 64'h8000_0000_0000_0000);
        send_request(kfr_pkg::OP_READ,  3'd3, 3'd2, '0, '1);
        send_request(kfr_pkg::OP_WRITE, 3'd2, 3'd2, 64'ha5a5_a5a5_5a5a_5a5a, '1);
        send_request(kfr_pkg::OP_ROUND, 3'd2, 3'd2, '0, 64'h8000_0000_8000_8008);
        send_request(kfr_pkg::OP_READ,  3'd0, 3'd4, '0, '0);
        wait_for_results();
    endtask

    // Random requests in bursts of random length; gaps land on every phase
    // of a request, long bursts give stretches with no gaps.
    task automatic test_random_traffic();
        int         sent;
        int         burst;
        int         pick;
        logic       paused;
        logic [1:0] op;
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_REQUESTS) begin
            burst = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 12);
            for (int k = 0; k < burst && sent < RANDOM_REQUESTS; k++) begin
                pick = $urandom_range(0, 19);
                if (pick < 8)       op = kfr_pkg::OP_WRITE;
                else if (pick < 13) op = kfr_pkg::OP_READ;
                else if (pick < 19) op = kfr_pkg::OP_ROUND;
                else                op = OP_UNUSED;
                send_request(op, rand_coord(), rand_coord(), rand_lane(), rand_lane());
                sent++;
            end
            // Pause for a full drain once mid-run, and now and then besides
            if (!paused && sent >= RANDOM_REQUESTS / 2) begin
                wait_for_results();
                paused = 1'b1;
            end else if ($urandom_range(0, 15) == 0) begin
                wait_for_results();
            end else begin
                hold_off($urandom_range(0, 6));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          <= 1'b0;
        start            <= 1'b0;
        i_opcode         <= kfr_pkg::OP_READ;
        i_lane_x         <= '0;
        i_lane_y         <= '0;
        i_lane_value     <= '0;
        i_round_constant <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_lane_access();
        test_bad_coordinates();
        test_round_cases();
        test_random_traffic();

        // Drain, then watch a few more cycles for stray results
        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (lane_expect_q.size() != 0) begin
            note_fault($sformatf("%0d results never arrived", lane_expect_q.size()));
        end
        if (fault_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
